### hw/rtl/hts_pkg.sv
// shared types and constants of the hysteresis thermostat scheduler
package hts_pkg;

  // milliseconds in one minute
  localparam logic [31:0] MS_PER_MINUTE = 32'd60000;

  // minute = ((ms >> 5) * MINUTE_RECIP) >> MINUTE_SHIFT, exact for every 32-bit time
  // (60000 = 32 * 1875, reciprocal of 1875 rounded up to 28 bits)
  localparam int          MINUTE_PRESHIFT = 5;
  localparam int          MINUTE_RECIP_W  = 28;
  localparam logic [27:0] MINUTE_RECIP    = 28'd146601551;
  localparam int          MINUTE_SHIFT    = 38;

  // item operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  // mode register codes
  localparam logic MODE_FIXED   = 1'b0;
  localparam logic MODE_PROGRAM = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE      = 2'd0;
  localparam logic [1:0] CFG_TARGET    = 2'd1;
  localparam logic [1:0] CFG_STOP_TIME = 2'd2;
  localparam logic [1:0] CFG_HYST      = 2'd3;

  // hysteresis value after reset
  localparam logic [7:0] HYST_RESET = 8'd16;

  // one program table point
  typedef struct packed {
    logic [15:0]        minute;
    logic signed [11:0] temp;
  } point_t;

endpackage

### hw/rtl/hts_ram.sv
// generic single-port-write, single-port-read ram with registered read
module hts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/hts_table.sv
// program table: ram plus per-entry valid bits so unwritten points read as zero
module hts_table #(
  parameter int POINTS = 8,
  localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  hts_pkg::point_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output hts_pkg::point_t rd_data
);

  logic [POINTS-1:0]                 vld;
  logic                              vld_q;
  logic [$bits(hts_pkg::point_t)-1:0] ram_q;

  hts_ram #(
    .WIDTH ($bits(hts_pkg::point_t)),
    .DEPTH (POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // valid bits, cleared at reset, sampled alongside the ram read
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= vld[rd_addr];
      end
    end
  end

  // never-written entries read as zero
  assign rd_data = vld_q ? hts_pkg::point_t'(ram_q) : '0;

endmodule

### hw/rtl/hts_minute_div.sv
// current minute from milliseconds: shift out the factor 32, then multiply by a reciprocal
module hts_minute_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] now_ms,
  output logic        done,
  output logic [15:0] minute
);

  localparam int NW = 32 - hts_pkg::MINUTE_PRESHIFT;
  localparam int RW = hts_pkg::MINUTE_RECIP_W;
  localparam int PW = NW + RW;

  logic          busy;
  logic [NW-1:0] num;
  logic [PW-1:0] prod;

  // start latches the shifted time, then the busy state forms the product and raises done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        num  <= now_ms[31:hts_pkg::MINUTE_PRESHIFT];
      end else if (busy) begin
        busy <= 1'b0;
        done <= 1'b1;
        prod <= PW'(num) * PW'(hts_pkg::MINUTE_RECIP);
      end
    end
  end

  // minute truncated to 16 bits
  assign minute = prod[hts_pkg::MINUTE_SHIFT +: 16];

endmodule

### hw/rtl/hysteresis_thermostat_scheduler_core.sv
// top level of the hysteresis thermostat scheduler
//
//  channel  direction  handshake               payload
//  in       input      in_valid / in_ready     operation .. point_temp
//  out      output     out_valid / out_ready   heater, alarm, active_point, active_target
//  cfg      input      cfg_wr_en               cfg_index, cfg_wdata
//
// table writes and fixed-mode samples go from accept to the final decision and on to the
// result register; a new item is taken only once the last one has reached that register.
// program-mode samples first pass the reciprocal minute divider, then a scan that reads
// the points in table order and stops at the first point whose minute is still ahead,
// then the final decision (each ram read overlaps the check of the previous point).
// reset clears flags, config registers and the table valid bits; no clearing pass.
// one item in flight; a full result register stalls completion, not the divider or scan.
module hysteresis_thermostat_scheduler_core #(
  parameter int POINTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic signed [11:0] temperature,
  input  logic               sensor_valid,
  input  logic [31:0]        now_ms,
  input  logic [2:0]         point_index,
  input  logic [15:0]        point_minute,
  input  logic signed [11:0] point_temp,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               heater,
  output logic               alarm,
  output logic [3:0]         active_point,
  output logic signed [11:0] active_target,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int CW = $clog2(POINTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_FIN
  } state_t;

  state_t state;

  // configuration registers
  logic               mode;
  logic signed [11:0] target_temp;
  logic [31:0]        stop_time_ms;
  logic [7:0]         hysteresis;

  // held control flags
  logic heater_flag;
  logic alarm_flag;

  // latched item
  logic               op_q;
  logic signed [11:0] temp_q;
  logic               sens_q;
  logic [31:0]        now_q;
  logic [2:0]         pidx_q;
  logic [15:0]        pmin_q;
  logic signed [11:0] ptemp_q;

  // schedule scan
  logic [CW-1:0]      rd_idx;
  logic [CW-1:0]      chk_idx;
  logic               chk_pend;
  logic [CW-1:0]      sched_point;
  logic signed [11:0] sched_target;

  logic               accept;
  logic               div_start;
  logic               div_done;
  logic [15:0]        minute;
  logic               tbl_wr;
  logic               tbl_rd;
  hts_pkg::point_t    tbl_wdata;
  hts_pkg::point_t    tbl_q;
  logic               can_load;

  // result of the final decision
  logic               heat_n;
  logic               alarm_n;
  logic [CW-1:0]      point_n;
  logic signed [11:0] target_n;
  logic               do_reg;
  logic signed [13:0] low_bound;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign div_start = accept && (operation == hts_pkg::OP_SAMPLE) &&
                     (mode == hts_pkg::MODE_PROGRAM);
  assign can_load  = !out_valid || out_ready;

  hts_minute_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .now_ms (now_ms),
    .done   (div_done),
    .minute (minute)
  );

  // table access: writes at completion, reads during the scan
  assign tbl_wr    = (state == S_FIN) && can_load && (op_q == hts_pkg::OP_WRITE) &&
                     (32'(pidx_q) < 32'(POINTS));
  assign tbl_wdata = '{minute: pmin_q, temp: ptemp_q};
  assign tbl_rd    = (state == S_SCAN) && (32'(rd_idx) < 32'(POINTS));

  hts_table #(
    .POINTS (POINTS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tbl_wr),
    .wr_addr (AW'(pidx_q)),
    .wr_data (tbl_wdata),
    .rd_en   (tbl_rd),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (tbl_q)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= hts_pkg::MODE_FIXED;
      target_temp  <= '0;
      stop_time_ms <= '0;
      hysteresis   <= hts_pkg::HYST_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        hts_pkg::CFG_MODE:      mode         <= cfg_wdata[0];
        hts_pkg::CFG_TARGET:    target_temp  <= cfg_wdata[11:0];
        hts_pkg::CFG_STOP_TIME: stop_time_ms <= cfg_wdata;
        hts_pkg::CFG_HYST:      hysteresis   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // final decision: target selection and hysteresis regulation
  always_comb begin
    heat_n   = heater_flag;
    alarm_n  = alarm_flag;
    point_n  = '0;
    target_n = '0;
    do_reg   = 1'b0;
    if (op_q == hts_pkg::OP_SAMPLE) begin
      if (mode == hts_pkg::MODE_FIXED) begin
        target_n = target_temp;
        do_reg   = (stop_time_ms == '0) || (now_q < stop_time_ms);
      end else begin
        point_n  = sched_point;
        target_n = sched_target;
        do_reg   = (sched_point != CW'(POINTS));
      end
      // stopped or schedule finished: heater off, alarm cleared
      heat_n  = 1'b0;
      alarm_n = 1'b0;
    end
    low_bound = 14'(target_n) - $signed({6'b0, hysteresis});
    if (do_reg) begin
      if (!sens_q) begin
        alarm_n = 1'b1;
        heat_n  = 1'b0;
      end else begin
        alarm_n = 1'b0;
        if (temp_q >= target_n) begin
          heat_n = 1'b0;
        end else if (14'(temp_q) < low_bound) begin
          heat_n = 1'b1;
        end else begin
          heat_n = heater_flag;
        end
      end
    end
  end

  // control sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      heater_flag <= 1'b0;
      alarm_flag  <= 1'b0;
      chk_pend    <= 1'b0;
    end else begin
      // result taken while no new one is loaded
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q    <= operation;
            temp_q  <= temperature;
            sens_q  <= sensor_valid;
            now_q   <= now_ms;
            pidx_q  <= point_index;
            pmin_q  <= point_minute;
            ptemp_q <= point_temp;
            state   <= div_start ? S_DIV : S_FIN;
          end
        end
        S_DIV: begin
          if (div_done) begin
            rd_idx   <= '0;
            chk_pend <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue the next read while checking the previous one
          if (tbl_rd) begin
            rd_idx <= rd_idx + 1'b1;
          end
          chk_pend <= tbl_rd;
          chk_idx  <= rd_idx;
          if (chk_pend) begin
            if (minute < tbl_q.minute) begin
              sched_point  <= chk_idx;
              sched_target <= tbl_q.temp;
              state        <= S_FIN;
            end else if (chk_idx == CW'(POINTS - 1)) begin
              sched_point  <= CW'(POINTS);
              sched_target <= '0;
              state        <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (can_load) begin
            out_valid     <= 1'b1;
            heater        <= heat_n;
            alarm         <= alarm_n;
            active_point  <= 4'(point_n);
            active_target <= target_n;
            heater_flag   <= heat_n;
            alarm_flag    <= alarm_n;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/tb_top.sv
// self-checking testbench for the hysteresis thermostat scheduler core
`timescale 1ns / 1ps

module tb_top;

  localparam int POINTS         = 8;
  localparam int PW             = $clog2(POINTS);
  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int SETTLE_CYCLES  = 40;
  localparam int LONG_STALL     = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  // one input item and one result item
  typedef struct packed {
    logic               op;
    logic signed [11:0] temp;
    logic               valid;
    logic [31:0]        now;
    logic [2:0]         pidx;
    logic [15:0]        pmin;
    logic signed [11:0] ptemp;
  } sched_item_t;

  typedef struct packed {
    logic               heater;
    logic               alarm;
    logic [3:0]         point;
    logic signed [11:0] target;
  } sched_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               operation = hts_pkg::OP_SAMPLE;
  logic signed [11:0] temperature = '0;
  logic               sensor_valid = 1'b0;
  logic [31:0]        now_ms = '0;
  logic [2:0]         point_index = '0;
  logic [15:0]        point_minute = '0;
  logic signed [11:0] point_temp = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               heater;
  logic               alarm;
  logic [3:0]         active_point;
  logic signed [11:0] active_target;
  logic               cfg_wr_en = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_wdata = '0;

  hysteresis_thermostat_scheduler_core #(
    .POINTS(POINTS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .temperature  (temperature),
    .sensor_valid (sensor_valid),
    .now_ms       (now_ms),
    .point_index  (point_index),
    .point_minute (point_minute),
    .point_temp   (point_temp),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .heater       (heater),
    .alarm        (alarm),
    .active_point (active_point),
    .active_target(active_target),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predicted thermostat state and registers
  logic               mode_q;
  logic signed [11:0] target_q;
  logic [31:0]        stop_q;
  logic [7:0]         hyst_q;
  logic               heater_q;
  logic               alarm_q;
  hts_pkg::point_t    sched_table [POINTS];

  sched_item_t   pending_items[$];
  sched_result_t expected_results[$];
  sched_item_t   held_item;
  int            send_gap = 0;
  int            recv_hold = 0;
  int            stall_requests = 0;
  int            stall_served = 0;
  int            stuck_cycles = 0;
  int            mismatch_count = 0;
  int            table_span = 0;
  bit            quiet_phase = 1'b0;

  // on/off decision with hysteresis band below the target
  function automatic void regulate(input logic ok, input logic signed [11:0] temp,
                                   input logic signed [11:0] tgt);
    int t;
    int lim;
    t = int'(temp);
    lim = int'(tgt) - int'(hyst_q);
    if (!ok) begin
      alarm_q = 1'b1;
      heater_q = 1'b0;
    end else begin
      if (t >= int'(tgt)) heater_q = 1'b0;
      if (t < lim) heater_q = 1'b1;
      alarm_q = 1'b0;
    end
  endfunction

  // advance the predicted state by one item and return its result
  function automatic sched_result_t thermostat_step(input sched_item_t it);
    sched_result_t r;
    logic [31:0]   minute_full;
    logic [15:0]   minute;
    int            slot;
    r = '0;
    if (it.op == hts_pkg::OP_WRITE) begin
      if (int'(it.pidx) < POINTS) begin
        sched_table[it.pidx].minute = it.pmin;
        sched_table[it.pidx].temp = it.ptemp;
      end
    end else if (mode_q == hts_pkg::MODE_FIXED) begin
      r.target = target_q;
      if (stop_q == 32'd0 || it.now < stop_q) begin
        regulate(it.valid, it.temp, target_q);
      end else begin
        heater_q = 1'b0;
        alarm_q = 1'b0;
      end
    end else begin
      minute_full = it.now / hts_pkg::MS_PER_MINUTE;
      minute = minute_full[15:0];
      slot = POINTS;
      for (int i = POINTS - 1; i >= 0; i--) begin
        if (minute < sched_table[PW'(i)].minute) slot = i;
      end
      r.point = 4'(slot);
      if (slot < POINTS) begin
        r.target = sched_table[PW'(slot)].temp;
        regulate(it.valid, it.temp, sched_table[PW'(slot)].temp);
      end else begin
        heater_q = 1'b0;
        alarm_q = 1'b0;
      end
    end
    r.heater = heater_q;
    r.alarm = alarm_q;
    return r;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (quiet_phase) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  function automatic int rand_temp();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  // every field random, operation included
  function automatic sched_item_t noise_item();
    sched_item_t it;
    it.op = 1'($urandom_range(0, 1));
    it.temp = 12'($urandom_range(0, 4095));
    it.valid = 1'($urandom_range(0, 1));
    it.now = $urandom;
    it.pidx = 3'($urandom_range(0, 7));
    it.pmin = 16'($urandom_range(0, 65535));
    it.ptemp = 12'($urandom_range(0, 4095));
    return it;
  endfunction

  function automatic sched_item_t sample_item(input int temp, input logic ok,
                                              input logic [31:0] now);
    sched_item_t it;
    it = noise_item();
    it.op = hts_pkg::OP_SAMPLE;
    it.temp = temp[11:0];
    it.valid = ok;
    it.now = now;
    return it;
  endfunction

  function automatic sched_item_t write_item(input int idx, input int minute, input int temp);
    sched_item_t it;
    it = noise_item();
    it.op = hts_pkg::OP_WRITE;
    it.pidx = idx[2:0];
    it.pmin = minute[15:0];
    it.ptemp = temp[11:0];
    return it;
  endfunction

  // temperature mostly around the band of a likely target
  function automatic int pick_temp();
    int tgt;
    int t;
    tgt = (mode_q == hts_pkg::MODE_FIXED) ? int'(target_q) :
          int'(sched_table[PW'($urandom_range(0, 7))].temp);
    if ($urandom_range(0, 4) == 0) return rand_temp();
    t = tgt - int'(hyst_q) - 4 + int'($urandom_range(0, int'(hyst_q) + 8));
    if (t > 2047) t = 2047;
    if (t < -2048) t = -2048;
    return t;
  endfunction

  // time mostly inside the schedule or around the stop time
  function automatic logic [31:0] pick_now();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 12) return $urandom;
    if (mode_q == hts_pkg::MODE_PROGRAM) begin
      return 32'($urandom_range(0, table_span + 3)) * hts_pkg::MS_PER_MINUTE
             + 32'($urandom_range(0, 59999));
    end
    if (stop_q != 32'd0 && r < 70) return stop_q + 32'($urandom_range(0, 64)) - 32'd32;
    return 32'($urandom_range(0, 100000));
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      hts_pkg::CFG_MODE:      mode_q = data[0];
      hts_pkg::CFG_TARGET:    target_q = data[11:0];
      hts_pkg::CFG_STOP_TIME: stop_q = data;
      hts_pkg::CFG_HYST:      hyst_q = data[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_config(input logic md, input int tgt, input logic [31:0] stop,
                            input int hy);
    write_reg(hts_pkg::CFG_MODE, {31'd0, md});
    write_reg(hts_pkg::CFG_TARGET, 32'(tgt));
    write_reg(hts_pkg::CFG_STOP_TIME, stop);
    write_reg(hts_pkg::CFG_HYST, 32'(hy));
  endtask

  // wait until every item is through and the block has settled
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  // sender: presents pending items, predicts each accepted one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(thermostat_step(held_item));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          held_item = pending_items.pop_front();
          operation <= held_item.op;
          temperature <= held_item.temp;
          sensor_valid <= held_item.valid;
          now_ms <= held_item.now;
          point_index <= held_item.pidx;
          point_minute <= held_item.pmin;
          point_temp <= held_item.ptemp;
          in_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result against the oldest prediction
  always @(posedge clk) begin
    sched_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_hold <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with nothing expected, expected none, got heater %0d alarm %0d",
                   $time, heater, alarm);
        end else begin
          want = expected_results.pop_front();
          check_field("heater", int'(want.heater), int'(heater));
          check_field("alarm", int'(want.alarm), int'(alarm));
          check_field("active_point", int'(want.point), int'(active_point));
          check_field("active_target", int'(want.target), int'(active_target));
        end
      end
      if (stall_requests != stall_served) begin
        stall_served <= stall_requests;
        recv_hold <= LONG_STALL;
        out_ready <= 1'b0;
      end else if (recv_hold > 0) begin
        recv_hold <= recv_hold - 1;
        out_ready <= 1'b0;
      end else begin
        recv_hold <= pick_gap();
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any item moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // stimulus sequence
  initial begin
    int          tgt;
    int          hy;
    int          m;
    int          r;
    logic [31:0] stop;

    mode_q = hts_pkg::MODE_FIXED;
    target_q = '0;
    stop_q = '0;
    hyst_q = hts_pkg::HYST_RESET;
    heater_q = 1'b0;
    alarm_q = 1'b0;
    for (int i = 0; i < POINTS; i++) sched_table[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // fixed mode at reset values: band edges, extremes, undefined sample, table writes
    pending_items.push_back(sample_item(0, 1'b1, 32'd0));
    pending_items.push_back(sample_item(-17, 1'b1, 32'd5));
    pending_items.push_back(sample_item(-16, 1'b1, 32'd6));
    pending_items.push_back(sample_item(2047, 1'b1, 32'd7));
    pending_items.push_back(sample_item(-2048, 1'b1, 32'hFFFF_FFFF));
    pending_items.push_back(sample_item(-2048, 1'b0, 32'd8));
    pending_items.push_back(write_item(0, 65535, -2048));
    pending_items.push_back(write_item(7, 0, 2047));
    wait_idle();

    // program mode: points in force, minute boundaries, finished schedule
    write_reg(hts_pkg::CFG_MODE, {31'd0, hts_pkg::MODE_PROGRAM});
    pending_items.push_back(sample_item(0, 1'b1, 32'd0));
    pending_items.push_back(write_item(0, 2, 320));
    pending_items.push_back(write_item(1, 5, -100));
    pending_items.push_back(sample_item(100, 1'b1, 32'd119999));
    pending_items.push_back(sample_item(100, 1'b1, 32'd120000));
    pending_items.push_back(sample_item(100, 1'b1, 32'd300000));
    pending_items.push_back(sample_item(0, 1'b0, 32'd0));
    pending_items.push_back(sample_item(0, 1'b1, 32'hFFFF_FFFF));
    wait_idle();

    // fixed mode with a stop time, widest band, then zero band at the bottom
    set_config(hts_pkg::MODE_FIXED, 2047, 32'd1000, 255);
    pending_items.push_back(sample_item(1700, 1'b1, 32'd999));
    pending_items.push_back(sample_item(1700, 1'b1, 32'd1000));
    pending_items.push_back(sample_item(0, 1'b0, 32'hFFFF_FFFF));
    pending_items.push_back(sample_item(2047, 1'b1, 32'd0));
    wait_idle();
    set_config(hts_pkg::MODE_FIXED, -2048, 32'd0, 0);
    pending_items.push_back(sample_item(-2048, 1'b1, 32'd0));
    pending_items.push_back(sample_item(-2048, 1'b0, 32'd1));
    wait_idle();

    // random phases over several register settings
    for (int p = 0; p < PHASES; p++) begin
      tgt = (p == 0) ? -2048 : (p == 2) ? 2047 : rand_temp();
      hy = (p == 1 || p == 4) ? 0 : (p == 3) ? 255 : int'($urandom_range(1, 64));
      stop = (p == 0) ? 32'h8000_0000 : (p == 4) ? 32'hFFFF_FFFF :
             (p == 6) ? 32'($urandom_range(1000, 1000000)) : 32'd0;
      set_config((p % 2 == 1) ? hts_pkg::MODE_PROGRAM : hts_pkg::MODE_FIXED, tgt, stop, hy);
      quiet_phase = (p == 3 || p == 6);
      m = 0;
      if (mode_q == hts_pkg::MODE_PROGRAM) begin
        // a well-formed schedule first
        for (int i = 0; i < POINTS; i++) begin
          m += int'($urandom_range(0, 30));
          pending_items.push_back(write_item(i, m, int'($urandom_range(0, 800)) - 200));
        end
        table_span = m;
      end
      for (int n = m > 0 ? POINTS : 0; n < ITEMS_PER_PHASE; n++) begin
        r = int'($urandom_range(0, 99));
        if (r < 8) pending_items.push_back(noise_item());
        else if (r < 18)
          pending_items.push_back(write_item(int'($urandom_range(0, 7)),
                                             int'($urandom_range(0, table_span + 4)),
                                             rand_temp()));
        else
          pending_items.push_back(sample_item(pick_temp(), $urandom_range(0, 9) != 0,
                                              pick_now()));
      end
      if (p == 5) stall_requests++;
      wait_idle();
    end

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
